// ===== rtl/qpe_pkg.sv =====
// qpe_pkg: shared constants, opcodes and types of the qoi pixel encoder
// used by qpe_lookup, qpe_encode, qpe_byte_out and the top unit; depends on nothing

package qpe_pkg;

   localparam int unsigned IndexEntries = 64;
   localparam int unsigned PosW         = $clog2(IndexEntries);
   localparam int unsigned ChanW        = 8;
   localparam int unsigned PixelW       = 4 * ChanW;
   localparam int unsigned MaxBytes     = 6;
   localparam int unsigned BodyBytes    = MaxBytes - 1;
   localparam int unsigned CntW         = $clog2(MaxBytes + 1);
   localparam int unsigned RunW         = 6;
   localparam int unsigned HashW        = 13;

   localparam logic [RunW-1:0] RunMax = 6'd62;

   localparam logic [7:0] OpIndex = 8'h00;
   localparam logic [7:0] OpDiff  = 8'h40;
   localparam logic [7:0] OpLuma  = 8'h80;
   localparam logic [7:0] OpRun   = 8'hC0;
   localparam logic [7:0] OpRgb   = 8'hFE;
   localparam logic [7:0] OpRgba  = 8'hFF;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] alpha;
   } pixel_type;

   localparam pixel_type PixelReset = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};
   localparam pixel_type PixelZero  = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0};

   // pixel with its index entry, handed from lookup to encode
   typedef struct packed {
      pixel_type        px;
      logic             last;
      logic [PosW-1:0]  pos;
      pixel_type        entry;
   } lookup_type;

   // what the encode stage commits back to the index
   typedef struct packed {
      logic             fire;
      logic             write;
      logic             clear;
      logic [PosW-1:0]  pos;
      pixel_type        px;
   } commit_type;

   // bytes of one pixel, first byte in slot 0
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CntW-1:0]          count;
   } chunk_type;

endpackage

// ===== rtl/qpe_if.sv =====
// qpe_if: handshake channels of the qoi pixel encoder (pixel, byte, csr)
// depends on nothing

interface qpe_pixel_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface qpe_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_item;

   modport source (output valid, out_byte, last_of_item, input ready);
   modport sink   (input valid, out_byte, last_of_item, output ready);
endinterface

interface qpe_csr_if;
   logic valid;
   logic ready;
   logic alpha_enable;

   modport source (output valid, alpha_enable, input ready);
   modport sink   (input valid, alpha_enable, output ready);
endinterface

// ===== rtl/qpe_ram.sv =====
// qpe_ram: generic single write port, single read port ram, registered read
// depends on nothing

module qpe_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qpe_lookup.sv =====
// qpe_lookup: pixel intake, qoi hash, colour index ram with valid bits and
// write forwarding; depends on qpe_pkg, qpe_if, qpe_ram

module qpe_lookup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  alpha_enable,
   qpe_pixel_if.sink             req_if,
   input  qpe_pkg::commit_type   cmt,
   output logic                  s1_valid,
   output qpe_pkg::lookup_type   s1
);

   qpe_pkg::pixel_type          px_in;
   logic [qpe_pkg::HashW-1:0]   hash;
   logic [qpe_pkg::PosW-1:0]    pos_in;
   logic                        accept;
   logic                        same_wr;
   logic [qpe_pkg::PixelW-1:0]  ram_q;

   logic [qpe_pkg::IndexEntries-1:0] valid_ff, valid_in;
   logic                        s1_valid_ff, s1_valid_in;
   qpe_pkg::pixel_type          px_ff;
   logic                        last_ff;
   logic [qpe_pkg::PosW-1:0]    pos_ff;
   logic                        ev_ff, ev_in;
   logic                        fwd_ff;
   qpe_pkg::pixel_type          fwd_px_ff;

   assign req_if.ready = !s1_valid_ff || cmt.fire;
   assign accept       = req_if.valid && req_if.ready;

   assign px_in.red   = req_if.red;
   assign px_in.green = req_if.green;
   assign px_in.blue  = req_if.blue;
   assign px_in.alpha = alpha_enable ? req_if.alpha : 8'd255;

   assign hash = qpe_pkg::HashW'(px_in.red)   * qpe_pkg::HashW'(3)
               + qpe_pkg::HashW'(px_in.green) * qpe_pkg::HashW'(5)
               + qpe_pkg::HashW'(px_in.blue)  * qpe_pkg::HashW'(7)
               + qpe_pkg::HashW'(px_in.alpha) * qpe_pkg::HashW'(11);
   assign pos_in = hash[qpe_pkg::PosW-1:0];

   // a write in the same cycle as the read does not reach the ram output
   assign same_wr = cmt.fire && cmt.write && (cmt.pos == pos_in);

   always_comb begin
      priority if (cmt.fire && cmt.clear) begin
         ev_in = 1'b0;
      end else if (same_wr) begin
         ev_in = 1'b1;
      end else begin
         ev_in = valid_ff[pos_in];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmt.fire && cmt.write) begin
         valid_in[cmt.pos] = 1'b1;
      end
      if (cmt.fire && cmt.clear) begin
         valid_in = '0;
      end
   end

   always_comb begin
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (cmt.fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff     <= px_in;
         last_ff   <= req_if.last_pixel;
         pos_ff    <= pos_in;
         ev_ff     <= ev_in;
         fwd_ff    <= same_wr;
         fwd_px_ff <= cmt.px;
      end
   end

   qpe_ram #(
      .Width (qpe_pkg::PixelW),
      .Depth (qpe_pkg::IndexEntries)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (cmt.fire && cmt.write),
      .wr_addr (cmt.pos),
      .wr_data (cmt.px),
      .rd_en   (accept),
      .rd_addr (pos_in),
      .rd_data (ram_q)
   );

   assign s1_valid = s1_valid_ff;
   assign s1.px    = px_ff;
   assign s1.last  = last_ff;
   assign s1.pos   = pos_ff;
   assign s1.entry = !ev_ff ? qpe_pkg::PixelZero
                   : fwd_ff ? fwd_px_ff
                   : qpe_pkg::pixel_type'(ram_q);

endmodule

// ===== rtl/qpe_encode.sv =====
// qpe_encode: chunk selection against previous pixel, index entry and run
// depends on qpe_pkg

module qpe_encode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  qpe_pkg::lookup_type   s1,
   input  logic                  out_free,
   output qpe_pkg::commit_type   cmt,
   output qpe_pkg::chunk_type    chunk
);

   qpe_pkg::pixel_type         prev_ff, prev_in;
   logic [qpe_pkg::RunW-1:0]   run_ff, run_in;
   logic [qpe_pkg::RunW-1:0]   run_inc;
   logic [qpe_pkg::RunW-1:0]   run_after;
   logic                       same;
   logic                       hit;
   logic                       pre_v;
   logic [7:0]                 pre_byte;
   logic [qpe_pkg::BodyBytes-1:0][7:0] body;
   logic [qpe_pkg::CntW-1:0]   body_n;
   logic signed [7:0]          vr, vg, vb, vgr, vgb;
   logic                       small_diff, luma_fit;
   logic                       fire;

   assign same    = (s1.px == prev_ff);
   assign hit     = (s1.entry == s1.px);
   assign run_inc = run_ff + 6'd1;

   always_comb begin
      priority if (!same) begin
         run_after = '0;
      end else if (run_inc == qpe_pkg::RunMax) begin
         run_after = '0;
      end else begin
         run_after = run_inc;
      end
   end

   assign pre_v    = !same && (run_ff != '0);
   assign pre_byte = qpe_pkg::OpRun | {2'b00, 6'(run_ff - 6'd1)};

   assign vr  = s1.px.red   - prev_ff.red;
   assign vg  = s1.px.green - prev_ff.green;
   assign vb  = s1.px.blue  - prev_ff.blue;
   assign vgr = vr - vg;
   assign vgb = vb - vg;

   assign small_diff = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                    && (vb >= -8'sd2) && (vb <= 8'sd1);
   assign luma_fit   = (vgr >= -8'sd8) && (vgr <= 8'sd7) && (vg >= -8'sd32)
                    && (vg <= 8'sd31) && (vgb >= -8'sd8) && (vgb <= 8'sd7);

   always_comb begin
      body   = '0;
      body_n = '0;
      priority if (same) begin
         if (run_inc == qpe_pkg::RunMax) begin
            body[0] = qpe_pkg::OpRun | {2'b00, 6'(qpe_pkg::RunMax - 6'd1)};
            body_n  = qpe_pkg::CntW'(1);
         end else if (s1.last && (run_after != '0)) begin
            body[0] = qpe_pkg::OpRun | {2'b00, 6'(run_after - 6'd1)};
            body_n  = qpe_pkg::CntW'(1);
         end
      end else if (hit) begin
         body[0] = qpe_pkg::OpIndex | {2'b00, s1.pos};
         body_n  = qpe_pkg::CntW'(1);
      end else if (s1.px.alpha == prev_ff.alpha) begin
         priority if (small_diff) begin
            body[0] = qpe_pkg::OpDiff | {2'b00, 2'(vr + 8'sd2), 2'(vg + 8'sd2),
                                         2'(vb + 8'sd2)};
            body_n  = qpe_pkg::CntW'(1);
         end else if (luma_fit) begin
            body[0] = qpe_pkg::OpLuma | {2'b00, 6'(vg + 8'sd32)};
            body[1] = {4'(vgr + 8'sd8), 4'(vgb + 8'sd8)};
            body_n  = qpe_pkg::CntW'(2);
         end else begin
            body[0] = qpe_pkg::OpRgb;
            body[1] = s1.px.red;
            body[2] = s1.px.green;
            body[3] = s1.px.blue;
            body_n  = qpe_pkg::CntW'(4);
         end
      end else begin
         body[0] = qpe_pkg::OpRgba;
         body[1] = s1.px.red;
         body[2] = s1.px.green;
         body[3] = s1.px.blue;
         body[4] = s1.px.alpha;
         body_n  = qpe_pkg::CntW'(5);
      end
   end

   always_comb begin
      if (pre_v) begin
         chunk.bytes = {body, pre_byte};
      end else begin
         chunk.bytes = {8'h00, body};
      end
      chunk.count = body_n + qpe_pkg::CntW'(pre_v);
   end

   assign fire = s1_valid && ((chunk.count == '0) || out_free);

   assign cmt.fire  = fire;
   assign cmt.write = !same && !hit;
   assign cmt.clear = s1.last;
   assign cmt.pos   = s1.pos;
   assign cmt.px    = s1.px;

   always_comb begin
      prev_in = prev_ff;
      run_in  = run_ff;
      if (fire) begin
         if (s1.last) begin
            prev_in = qpe_pkg::PixelReset;
            run_in  = '0;
         end else begin
            prev_in = s1.px;
            run_in  = run_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= qpe_pkg::PixelReset;
         run_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         run_ff  <= run_in;
      end
   end

endmodule

// ===== rtl/qpe_byte_out.sv =====
// qpe_byte_out: output register that sends the bytes of one chunk in order
// depends on qpe_pkg, qpe_if

module qpe_byte_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  qpe_pkg::chunk_type    chunk,
   output logic                  free,
   qpe_byte_if.source            rsp_if
);

   logic [qpe_pkg::MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [qpe_pkg::CntW-1:0]          cnt_ff, cnt_in;
   logic                              take;

   assign take = rsp_if.valid && rsp_if.ready;
   assign free = (cnt_ff == '0) || ((cnt_ff == qpe_pkg::CntW'(1)) && rsp_if.ready);

   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      priority if (load) begin
         bytes_in = chunk.bytes;
         cnt_in   = chunk.count;
      end else if (take) begin
         bytes_in = {8'h00, bytes_ff[qpe_pkg::MaxBytes-1:1]};
         cnt_in   = cnt_ff - qpe_pkg::CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp_if.valid        = (cnt_ff != '0);
   assign rsp_if.out_byte     = bytes_ff[0];
   assign rsp_if.last_of_item = (cnt_ff == qpe_pkg::CntW'(1));

endmodule

// ===== rtl/qoi_pixel_encoder_unit.sv =====
// The encoder takes one RGB(A) pixel per cycle and turns it into qoi chunk
// words (run, index, diff, luma, rgb, rgba), one byte per word, the final
// byte of each pixel flagged by last_of_item. Steps: hash and colour index
// ram read, then chunk selection. A new pixel is taken every cycle as long
// as the output keeps up; a pixel of up to six bytes holds the output
// until all are sent, so multi-byte chunks slow the stream to the byte
// rate of the output port. The colour index is cleared at once after reset
// and after each last pixel. The user must write alpha_enable through the
// csr port only while no pixel is in flight; not enforced by the block.
// depends on qpe_pkg, qpe_if, qpe_lookup, qpe_encode, qpe_byte_out

module qoi_pixel_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   qpe_pixel_if.sink   req_if,
   qpe_byte_if.source  rsp_if,
   qpe_csr_if.sink     csr_if
);

   logic                  alpha_enable_ff, alpha_enable_in;
   logic                  s1_valid;
   qpe_pkg::lookup_type   s1;
   qpe_pkg::commit_type   cmt;
   qpe_pkg::chunk_type    chunk;
   logic                  out_free;

   assign csr_if.ready = 1'b1;
   assign alpha_enable_in = (csr_if.valid && csr_if.ready) ? csr_if.alpha_enable
                                                          : alpha_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_enable_ff <= 1'b1;
      end else begin
         alpha_enable_ff <= alpha_enable_in;
      end
   end

   qpe_lookup u_lookup (
      .clock        (clock),
      .reset        (reset),
      .alpha_enable (alpha_enable_ff),
      .req_if       (req_if),
      .cmt          (cmt),
      .s1_valid     (s1_valid),
      .s1           (s1)
   );

   qpe_encode u_encode (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .out_free (out_free),
      .cmt      (cmt),
      .chunk    (chunk)
   );

   qpe_byte_out u_byte_out (
      .clock  (clock),
      .reset  (reset),
      .load   (cmt.fire && (chunk.count != '0)),
      .chunk  (chunk),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/qpe_checker.sv =====
// qpe_checker: port level assertions of the qoi pixel encoder, with bind
// depends on qoi_pixel_encoder_unit ports only

module qpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_item
);

   // no word is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word offered after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_of_item))
      else $error("stalled word changed");

   // a pixel's bytes leave without gaps
   a_chunk_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> rsp_valid)
      else $error("gap inside the bytes of one pixel");

endmodule

bind qoi_pixel_encoder_unit qpe_checker u_qpe_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_out_byte     (rsp_if.out_byte),
   .rsp_last_of_item (rsp_if.last_of_item)
);

// ===== tb/qpe_chunk_checker.sv =====
// qpe_chunk_checker: watches the pixel, byte and csr channels of the qoi pixel encoder,
// predicts the chunk bytes of every accepted pixel and compares each byte word
// depends on qpe_pkg

module qpe_chunk_checker
   import qpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       px_valid,
   input  logic       px_ready,
   input  pixel_type  px_word,
   input  logic       px_last,
   input  logic       byte_valid,
   input  logic       byte_ready,
   input  logic [7:0] byte_code,
   input  logic       byte_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_alpha,
   output int         mismatches,
   output int         outstanding,
   output int         bytes_checked
);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } chunk_byte_type;

   chunk_byte_type  expected_bytes [$];
   chunk_byte_type  want;
   logic            alpha_on;
   pixel_type       prev_px;
   pixel_type       colour_table [IndexEntries];
   logic [RunW-1:0] run_len;
   int              fail_count = 0;
   int              checked = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t chunk check: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_image();
      prev_px = PixelReset;
      foreach (colour_table[i]) colour_table[i] = PixelZero;
      run_len = '0;
   endtask

   task automatic encode_pixel(input pixel_type raw, input logic last_px);
      pixel_type         p;
      int unsigned       hash;
      logic [PosW-1:0]   pos;
      logic signed [7:0] dr, dg, db, dgr, dgb;
      int                ir, ig, ib, igr, igb;
      logic [7:0]        burst [$];
      p = raw;
      if (!alpha_on) begin
         p.alpha = 8'd255;
      end
      if (p == prev_px) begin
         run_len++;
         if (run_len == RunMax) begin
            burst.push_back(OpRun | {2'b00, run_len - 1'b1});
            run_len = '0;
         end
      end else begin
         if (run_len != 0) begin
            burst.push_back(OpRun | {2'b00, run_len - 1'b1});
            run_len = '0;
         end
         hash = p.red * 3 + p.green * 5 + p.blue * 7 + p.alpha * 11;
         pos = hash[PosW-1:0];
         if (colour_table[pos] == p) begin
            burst.push_back(OpIndex | {2'b00, pos});
         end else begin
            colour_table[pos] = p;
            if (p.alpha == prev_px.alpha) begin
               // channel deltas wrap to signed 8 bits
               dr  = p.red - prev_px.red;
               dg  = p.green - prev_px.green;
               db  = p.blue - prev_px.blue;
               dgr = dr - dg;
               dgb = db - dg;
               ir  = int'(dr);
               ig  = int'(dg);
               ib  = int'(db);
               igr = int'(dgr);
               igb = int'(dgb);
               if (ir > -3 && ir < 2 && ig > -3 && ig < 2 && ib > -3 && ib < 2) begin
                  burst.push_back(OpDiff | 8'((ir + 2) * 16 + (ig + 2) * 4 + (ib + 2)));
               end else if (igr > -9 && igr < 8 && ig > -33 && ig < 32 &&
                            igb > -9 && igb < 8) begin
                  burst.push_back(OpLuma | 8'(ig + 32));
                  burst.push_back(8'((igr + 8) * 16 + (igb + 8)));
               end else begin
                  burst.push_back(OpRgb);
                  burst.push_back(p.red);
                  burst.push_back(p.green);
                  burst.push_back(p.blue);
               end
            end else begin
               burst.push_back(OpRgba);
               burst.push_back(p.red);
               burst.push_back(p.green);
               burst.push_back(p.blue);
               burst.push_back(p.alpha);
            end
         end
      end
      prev_px = p;
      if (last_px) begin
         if (run_len != 0) begin
            burst.push_back(OpRun | {2'b00, run_len - 1'b1});
         end
         clear_image();
      end
      foreach (burst[i]) begin
         expected_bytes.push_back('{code: burst[i], last: (i == burst.size() - 1)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         alpha_on = 1'b1;
         clear_image();
      end else begin
         if (byte_valid && byte_ready) begin
            checked++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("word %h arrived with no chunk byte pending",
                                         byte_code));
            end else begin
               want = expected_bytes.pop_front();
               if (byte_code !== want.code) begin
                  report_mismatch($sformatf("out_byte want %h got %h", want.code, byte_code));
               end
               if (byte_last !== want.last) begin
                  report_mismatch($sformatf("last_of_item want %b got %b on byte %h",
                                            want.last, byte_last, byte_code));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            alpha_on = csr_alpha;
         end
         if (px_valid && px_ready) begin
            encode_pixel(px_word, px_last);
         end
      end
      mismatches    <= fail_count;
      outstanding   <= expected_bytes.size();
      bytes_checked <= checked;
   end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: drives pixels and alpha_enable writes into qoi_pixel_encoder_unit under
// varying idle patterns and reports the verdict from the chunk checker
// depends on qpe_pkg, qpe_if, qoi_pixel_encoder_unit, qpe_chunk_checker

module tb_top;
   import qpe_pkg::*;

   localparam int WatchdogLimit = 1000;
   localparam int BlockPixels   = 75;
   localparam int HistoryDepth  = 8;
   localparam int HistW         = $clog2(HistoryDepth);

   logic      clock;
   logic      reset;
   int        tx_idle_pct;
   int        rx_idle_pct;
   int        stall_cycles = 0;
   int        mismatches;
   int        outstanding;
   int        bytes_checked;
   int        pixels_sent;
   int        images_sent;
   int        phase;
   logic      alpha_on;
   pixel_type last_sent;
   pixel_type history [HistoryDepth];

   qpe_pixel_if req_ch ();
   qpe_byte_if  rsp_ch ();
   qpe_csr_if   csr_ch ();

   qoi_pixel_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   qpe_chunk_checker u_chunk_check (
      .clock         (clock),
      .reset         (reset),
      .px_valid      (req_ch.valid),
      .px_ready      (req_ch.ready),
      .px_word       ({req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha}),
      .px_last       (req_ch.last_pixel),
      .byte_valid    (rsp_ch.valid),
      .byte_ready    (rsp_ch.ready),
      .byte_code     (rsp_ch.out_byte),
      .byte_last     (rsp_ch.last_of_item),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .csr_alpha     (csr_ch.alpha_enable),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("qoi_pixel_encoder_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic pixel_type px(input logic [7:0] r, g, b, a);
      return '{red: r, green: g, blue: b, alpha: a};
   endfunction

   task automatic send_pixel(input pixel_type p, input logic last_flag);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.red        <= p.red;
      req_ch.green      <= p.green;
      req_ch.blue       <= p.blue;
      req_ch.alpha      <= p.alpha;
      req_ch.last_pixel <= last_flag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixels_sent++;
      if (last_flag) begin
         images_sent++;
      end
      history[HistW'(pixels_sent % HistoryDepth)] = p;
      last_sent = p;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_alpha(input logic v);
      csr_ch.valid        <= 1'b1;
      csr_ch.alpha_enable <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      alpha_on = v;
   endtask

   task automatic random_block(input int count, input logic long_run);
      int              sent;
      int              kind;
      int              len;
      int              dg;
      int              i;
      pixel_type       p;
      logic [3:0][7:0] chans;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         p = last_sent;
         if (long_run || kind < 12) begin
            // runs, some long enough to hit the 62 limit
            len = (long_run || $urandom_range(3) == 0) ? $urandom_range(56, 70)
                                                      : $urandom_range(1, 8);
            long_run = 1'b0;
            for (i = 0; i < len; i++) begin
               if (!alpha_on) begin
                  p.alpha = 8'($urandom);
               end
               send_pixel(p, (i == len - 1) && ($urandom_range(99) < 3));
            end
            sent += len;
         end else begin
            if (kind < 30) begin
               p.red   = 8'(p.red + $urandom_range(3) - 2);
               p.green = 8'(p.green + $urandom_range(3) - 2);
               p.blue  = 8'(p.blue + $urandom_range(3) - 2);
            end else if (kind < 45) begin
               dg      = $urandom_range(63) - 32;
               p.green = 8'(p.green + dg);
               p.red   = 8'(p.red + dg + $urandom_range(15) - 8);
               p.blue  = 8'(p.blue + dg + $urandom_range(15) - 8);
            end else if (kind < 58) begin
               p = history[HistW'($urandom_range(HistoryDepth - 1))];
            end else if (kind < 72) begin
               p.red   = 8'($urandom);
               p.green = 8'($urandom);
               p.blue  = 8'($urandom);
            end else if (kind < 85) begin
               p = $urandom;
            end else begin
               chans = $urandom;
               for (i = 0; i < 4; i++) begin
                  if ($urandom_range(1) == 1) begin
                     chans[2'(i)] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
                  end
               end
               p = chans;
            end
            send_pixel(p, $urandom_range(99) < 3);
            sent++;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.red          <= '0;
      req_ch.green        <= '0;
      req_ch.blue         <= '0;
      req_ch.alpha        <= '0;
      req_ch.last_pixel   <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.alpha_enable <= 1'b1;
      rx_idle_pct         <= 53;
      tx_idle_pct = 25;
      pixels_sent = 0;
      images_sent = 0;
      alpha_on    = 1'b1;
      last_sent   = PixelReset;
      foreach (history[i]) history[i] = PixelZero;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_alpha(1'b1);
      // index hit on the first pixel of an image, then a run broken by a diff
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
      send_pixel(px(8'd1, 8'd0, 8'd254, 8'd0), 1'b0);
      send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
      send_pixel(px(8'd10, 8'd20, 8'd30, 8'd255), 1'b0);
      // luma, both range limits with wraparound, then an rgb and two diffs
      send_pixel(px(8'd15, 8'd23, 8'd40, 8'd255), 1'b0);
      send_pixel(px(8'd231, 8'd247, 8'd15, 8'd255), 1'b0);
      send_pixel(px(8'd13, 8'd22, 8'd38, 8'd255), 1'b0);
      send_pixel(px(8'd255, 8'd255, 8'd0, 8'd255), 1'b0);
      send_pixel(px(8'd0, 8'd0, 8'd255, 8'd255), 1'b0);
      send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
      // pending run flushed by the last pixel
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0), 1'b1);
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
      send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255), 1'b1);
      send_pixel(px(8'd128, 8'd127, 8'd1, 8'd254), 1'b1);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 53 : 0;
         rx_idle_pct <= (phase == 0) ? 53 : (phase == 1) ? 25 : 0;
         write_alpha(1'b0);
         random_block(BlockPixels, phase == 0);
         drain();
         write_alpha(1'b1);
         random_block(BlockPixels, 1'b0);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d pixels in %0d complete images, %0d chunk bytes checked",
               pixels_sent, images_sent, bytes_checked);
      $display("alpha_enable on and off, sender and receiver idling in three patterns");
      if (mismatches == 0 && outstanding == 0) begin
         $display("qoi_pixel_encoder_unit regression: pass");
      end else begin
         $display("qoi_pixel_encoder_unit regression: fail");
      end
      $finish;
   end

endmodule
